### hw/rtl/bqx_pkg.sv
// package: shared constants, types and arithmetic helpers for the biquad equalizer
package bqx_pkg;

   localparam int EQ_BANDS    = 5;
   localparam int SAMPLE_BITS = 16;
   localparam int COEF_BITS   = 24;
   localparam int DELAY_BITS  = 32;

   localparam int NBQ     = EQ_BANDS + 5;
   localparam int NCOEF   = NBQ * 5;
   localparam int NDELAY  = 2 * NBQ;
   localparam int BASS0   = EQ_BANDS + 1;
   localparam int SFRAC   = SAMPLE_BITS - 1;
   localparam int FRAC    = DELAY_BITS - 8;
   localparam int CFRAC   = COEF_BITS - 4;
   localparam int NLFRAC  = 24;
   localparam int CIDX_W  = $clog2(NCOEF);
   localparam int DIDX_W  = $clog2(NDELAY);
   localparam int BQ_W    = $clog2(NBQ);
   localparam int ACC_W   = DELAY_BITS + 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int CLIP_LIM = ((1 << SFRAC) * 98 + 50) / 100;
   localparam int K_ABS   = 78643;
   localparam int K_CUBE  = 209715;

   localparam logic [CSR_IDX_W-1:0] CSR_HEADROOM = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIX      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK     = 2'd3;

   localparam logic [0:0] OP_SAMPLE = 1'b0;
   localparam logic [0:0] OP_COEF   = 1'b1;

   typedef logic signed [DELAY_BITS-1:0] sig_type;
   typedef logic signed [COEF_BITS-1:0]  coef_type;

   // datapath operation codes
   localparam int DOP_W = 4;
   localparam logic [DOP_W-1:0] DOP_NOP    = 4'd0;
   localparam logic [DOP_W-1:0] DOP_LOADX  = 4'd1;  // x = sat(sample*headroom)
   localparam logic [DOP_W-1:0] DOP_BQ_Y   = 4'd2;  // y = sat(b0*v + z1)
   localparam logic [DOP_W-1:0] DOP_BQ_Z1  = 4'd3;  // z1 = sat(b1*v - a1*y + z2)
   localparam logic [DOP_W-1:0] DOP_BQ_Z2  = 4'd4;  // z2 = sat(b2*v - a2*y)
   localparam logic [DOP_W-1:0] DOP_DRIVE  = 4'd5;  // l = clip(e*drive)
   localparam logic [DOP_W-1:0] DOP_SQ     = 4'd6;
   localparam logic [DOP_W-1:0] DOP_CUBE   = 4'd7;
   localparam logic [DOP_W-1:0] DOP_ABS    = 4'd8;
   localparam logic [DOP_W-1:0] DOP_KCUBE  = 4'd9;
   localparam logic [DOP_W-1:0] DOP_SHAPE  = 4'd10; // h = sat(a + c)
   localparam logic [DOP_W-1:0] DOP_MIX    = 4'd11; // bass = h*mix
   localparam logic [DOP_W-1:0] DOP_OUT    = 4'd12; // final round and clip
   localparam logic [DOP_W-1:0] DOP_BQ_PASS = 4'd13; // keep value (disabled)
   localparam logic [DOP_W-1:0] DOP_SEL_X  = 4'd14; // v = x

   typedef struct packed {
      logic [DOP_W-1:0]  op;
      logic [BQ_W-1:0]   bq;
   } dp_cmd_type;

   typedef struct packed {
      logic coef_wr;
      logic [CIDX_W-1:0] coef_idx;
   } coef_cmd_type;

   function automatic logic signed [63:0] sat_sig(input logic signed [63:0] v);
      logic signed [63:0] mx;
      logic signed [63:0] mn;
      mx = (64'sd1 <<< (DELAY_BITS - 1)) - 64'sd1;
      mn = -(64'sd1 <<< (DELAY_BITS - 1));
      if (v > mx) return mx;
      else if (v < mn) return mn;
      return v;
   endfunction

   // v / 2^k rounded to nearest, ties away from zero
   function automatic logic signed [63:0] rshr(input logic signed [63:0] v, input int k);
      logic [63:0] u;
      if (k <= 0) return v;
      u = v[63] ? 64'(-v) : 64'(v);
      u = (u + (64'd1 << (k - 1))) >> k;
      return v[63] ? -$signed(u) : $signed(u);
   endfunction

endpackage

### hw/rtl/bqx_stream_if.sv
// interface: valid/ready channel carrying request or response transactions
interface bqx_req_if;
   logic                             valid;
   logic                             ready;
   logic [0:0]                       opcode;
   logic signed [15:0]               sample_in;
   logic [5:0]                       coef_index;
   logic signed [23:0]               coef_value;
   modport source (output valid, output opcode, output sample_in, output coef_index,
                   output coef_value, input ready);
   modport sink (input valid, input opcode, input sample_in, input coef_index,
                 input coef_value, output ready);
endinterface

interface bqx_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample_out;
   logic               clipped_now;
   logic [15:0]        clip_count;
   modport source (output valid, output sample_out, output clipped_now, output clip_count,
                   input ready);
   modport sink (input valid, input sample_out, input clipped_now, input clip_count,
                 output ready);
endinterface

### hw/rtl/bqx_ram.sv
// generic single-port-write ram with registered read
module bqx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

### hw/rtl/bqx_datapath.sv
// datapath: coefficient memory, delay registers and one shared multiply-accumulate
module bqx_datapath
   import bqx_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   input  coef_cmd_type       ccmd,
   input  logic [CIDX_W-1:0]  coef_rd_idx,
   input  logic signed [COEF_BITS-1:0] coef_wr_value,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic [15:0]        headroom_gain,
   input  logic [14:0]        bass_mix,
   input  logic [15:0]        bass_drive,
   output logic signed [SAMPLE_BITS-1:0] out_sample,
   output logic               out_clipped,
   output logic [15:0]        out_count
);
   logic [COEF_BITS-1:0] coef_rd;
   coef_type coef;
   sig_type z_ff [NDELAY];
   sig_type z_in_v;
   logic    z_wr;
   logic [DIDX_W-1:0] z_idx;
   sig_type x_ff, x_in;     // scaled input sample
   sig_type v_ff, v_in;     // current biquad input, becomes output
   sig_type y_ff, y_in;     // current biquad output
   sig_type bass_ff, bass_in;
   logic signed [26:0] l_ff, l_in, t_ff, t_in;  // shaper working values (Q.24)
   logic signed [63:0] prod_ff, prod_in;        // registered product
   logic [15:0] count_ff, count_in;
   logic signed [SAMPLE_BITS-1:0] res_ff, res_in;
   logic clip_ff, clip_in;
   logic signed [63:0] p, r, one, lim;
   logic [2:0] phase_ff;

   bqx_ram #(.WIDTH(COEF_BITS), .DEPTH(NCOEF)) u_coef_ram (
      .clock  (clock),
      .wr_en  (ccmd.coef_wr),
      .wr_addr(ccmd.coef_idx),
      .wr_data(coef_wr_value),
      .rd_addr(coef_rd_idx),
      .rd_data(coef_rd)
   );
   assign coef = coef_rd;

   // mulc: coefficient times signal, rounded at CFRAC, saturated
   function automatic logic signed [63:0] mulc(input coef_type c, input sig_type v);
      logic signed [63:0] pr;
      pr = 64'(c) * 64'(v);
      return sat_sig(rshr(pr, CFRAC));
   endfunction

   always_comb begin
      x_in = x_ff; v_in = v_ff; y_in = y_ff; bass_in = bass_ff;
      l_in = l_ff; t_in = t_ff; prod_in = prod_ff;
      count_in = count_ff; res_in = res_ff; clip_in = clip_ff;
      z_wr = 1'b0; z_idx = '0; z_in_v = '0;
      p = '0; r = '0;
      one = 64'sd1 <<< FRAC;
      lim = 64'(CLIP_LIM);
      unique case (cmd.op)
         DOP_LOADX: begin
            p = 64'(sample) * 64'($signed({1'b0, headroom_gain}));
            x_in = sig_type'(sat_sig(rshr(p, SFRAC + 15 - FRAC)));
            v_in = x_in;
            bass_in = '0;
         end
         DOP_SEL_X: v_in = x_ff;
         DOP_BQ_Y: begin
            z_idx = DIDX_W'({cmd.bq, 1'b0});
            y_in = sig_type'(sat_sig(mulc(coef, v_ff) + 64'(z_ff[z_idx])));
            prod_in = '0;
         end
         DOP_BQ_Z1: begin
            // in phases: first b1*v, then minus a1*y plus z2
            z_idx = DIDX_W'({cmd.bq, 1'b0});
            if (phase_ff == 3'd0) prod_in = mulc(coef, v_ff);
            else begin
               z_wr = 1'b1;
               z_in_v = sig_type'(sat_sig(prod_ff - mulc(coef, y_ff)
                                           + 64'(z_ff[DIDX_W'({cmd.bq, 1'b1})])));
            end
         end
         DOP_BQ_Z2: begin
            z_idx = DIDX_W'({cmd.bq, 1'b1});
            if (phase_ff == 3'd0) prod_in = mulc(coef, v_ff);
            else begin
               z_wr = 1'b1;
               z_in_v = sig_type'(sat_sig(prod_ff - mulc(coef, y_ff)));
               v_in = y_ff;
            end
         end
         DOP_BQ_PASS: ;
         DOP_DRIVE: begin
            p = rshr(64'(v_ff) * 64'($signed({1'b0, bass_drive})), 13);
            if (p > one) p = one;
            else if (p < -one) p = -one;
            l_in = 27'(p <<< (NLFRAC - FRAC));
         end
         DOP_SQ:    t_in = 27'(rshr(64'(l_ff) * 64'(l_ff), NLFRAC));
         DOP_CUBE:  t_in = 27'(rshr(64'(t_ff) * 64'(l_ff), NLFRAC));
         DOP_KCUBE: prod_in = rshr(64'(t_ff) * 64'(K_CUBE), 16);
         DOP_ABS:   t_in = 27'(rshr((l_ff[26] ? -64'(l_ff) : 64'(l_ff)) * 64'(K_ABS), 16));
         DOP_SHAPE: begin
            p = 64'(t_ff) + prod_ff;
            v_in = sig_type'(sat_sig(rshr(p, NLFRAC - FRAC)));
         end
         DOP_MIX: begin
            bass_in = sig_type'(rshr(64'(v_ff) * 64'($signed({1'b0, bass_mix})), 16));
            v_in = x_ff;
         end
         DOP_OUT: begin
            r = rshr(64'(v_ff) + 64'(bass_ff), FRAC - SFRAC);
            clip_in = (r > lim) || (r < -lim);
            if (r > lim) r = lim;
            else if (r < -lim) r = -lim;
            res_in = SAMPLE_BITS'(r);
            if (clip_in && count_ff != 16'hFFFF) count_in = count_ff + 16'd1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NDELAY; i++) z_ff[i] <= '0;
         count_ff <= '0;
         phase_ff <= '0;
      end else begin
         if (z_wr) z_ff[z_idx] <= z_in_v;
         count_ff <= count_in;
         phase_ff <= ((cmd.op == DOP_BQ_Z1 || cmd.op == DOP_BQ_Z2) && phase_ff == 3'd0)
                     ? 3'd1 : 3'd0;
      end
      x_ff <= x_in; v_ff <= v_in; y_ff <= y_in; bass_ff <= bass_in;
      l_ff <= l_in; t_ff <= t_in; prod_ff <= prod_in;
      res_ff <= res_in; clip_ff <= clip_in;
   end

   assign out_sample  = res_ff;
   assign out_clipped = clip_ff;
   assign out_count   = count_ff;
endmodule

### hw/rtl/bqx_ctrl.sv
// controller: sequences biquads, bass shaper and output for one sample
module bqx_ctrl
   import bqx_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              bass_on,
   input  logic [NBQ-1:0]    mask,
   input  logic              out_taken,
   output logic              busy,
   output logic              out_valid,
   output dp_cmd_type        cmd,
   output logic [CIDX_W-1:0] coef_rd_idx
);
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_LOAD  = 4'd1;
   localparam logic [3:0] ST_BQ    = 4'd2;  // coef fetch b0
   localparam logic [3:0] ST_Y     = 4'd3;
   localparam logic [3:0] ST_Z1A   = 4'd4;
   localparam logic [3:0] ST_Z1B   = 4'd5;
   localparam logic [3:0] ST_Z2A   = 4'd6;
   localparam logic [3:0] ST_Z2B   = 4'd7;
   localparam logic [3:0] ST_SHAPE = 4'd8;
   localparam logic [3:0] ST_OUT   = 4'd9;
   localparam logic [3:0] ST_HOLD  = 4'd10;

   logic [3:0] state_ff, state_in;
   logic [BQ_W-1:0] bq_ff, bq_in;
   logic [2:0] step_ff, step_in;
   logic [CIDX_W-1:0] base;
   logic [BQ_W-1:0] next_bq;
   logic bq_last;

   assign base = CIDX_W'(bq_ff) * CIDX_W'(5);
   // order: bass bq BASS0, BASS0+1, shaper, BASS0+2, BASS0+3, mix, then 0..EQ_BANDS
   always_comb begin
      next_bq = bq_ff + BQ_W'(1);
      bq_last = 1'b0;
      if (bq_ff == BQ_W'(BASS0 + 1)) next_bq = BQ_W'(BASS0 + 2);
      if (bq_ff == BQ_W'(BASS0 + 3)) next_bq = '0;
      if (bq_ff == BQ_W'(EQ_BANDS)) bq_last = 1'b1;
   end

   always_comb begin
      state_in = state_ff; bq_in = bq_ff; step_in = step_ff;
      cmd = '{op: DOP_NOP, bq: bq_ff};
      coef_rd_idx = base;
      unique case (state_ff)
         ST_IDLE: if (start) state_in = ST_LOAD;
         ST_LOAD: begin
            cmd.op = DOP_LOADX;
            bq_in = bass_on ? BQ_W'(BASS0) : '0;
            state_in = ST_BQ;
         end
         ST_BQ: begin
            coef_rd_idx = base;
            if (!mask[bq_ff]) begin
               cmd.op = DOP_BQ_PASS;
               state_in = ST_Z2B;
            end else state_in = ST_Y;
         end
         ST_Y: begin
            cmd.op = DOP_BQ_Y; coef_rd_idx = base + CIDX_W'(1); state_in = ST_Z1A;
         end
         ST_Z1A: begin
            cmd.op = DOP_BQ_Z1; coef_rd_idx = base + CIDX_W'(3); state_in = ST_Z1B;
         end
         ST_Z1B: begin
            cmd.op = DOP_BQ_Z1; coef_rd_idx = base + CIDX_W'(2); state_in = ST_Z2A;
         end
         ST_Z2A: begin
            cmd.op = DOP_BQ_Z2; coef_rd_idx = base + CIDX_W'(4); state_in = ST_Z2B;
         end
         ST_Z2B: begin
            if (mask[bq_ff]) cmd.op = DOP_BQ_Z2;
            if (bq_ff == BQ_W'(BASS0 + 1)) begin
               step_in = '0; state_in = ST_SHAPE;
            end else if (bq_ff == BQ_W'(BASS0 + 3)) begin
               step_in = 3'd6; state_in = ST_SHAPE;
            end else if (bq_last) state_in = ST_OUT;
            else state_in = ST_BQ;
            bq_in = next_bq;
            coef_rd_idx = CIDX_W'(next_bq) * CIDX_W'(5);
         end
         ST_SHAPE: begin
            step_in = step_ff + 3'd1;
            unique case (step_ff)
               3'd0: cmd.op = DOP_DRIVE;
               3'd1: cmd.op = DOP_SQ;
               3'd2: cmd.op = DOP_CUBE;
               3'd3: cmd.op = DOP_KCUBE;
               3'd4: cmd.op = DOP_ABS;
               3'd5: begin cmd.op = DOP_SHAPE; state_in = ST_BQ; end
               3'd6: begin cmd.op = DOP_MIX; state_in = ST_BQ; end
               default: state_in = ST_BQ;
            endcase
         end
         ST_OUT: begin cmd.op = DOP_OUT; state_in = ST_HOLD; end
         ST_HOLD: if (out_taken) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; bq_ff <= '0; step_ff <= '0;
      end else begin
         state_ff <= state_in; bq_ff <= bq_in; step_ff <= step_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign out_valid = (state_ff == ST_HOLD);
endmodule

### hw/rtl/biquad_eq_bass_exciter_core.sv
// top level: biquad equalizer with bass exciter
// Each sample transaction runs through a shared multiply-accumulate under a
// sequencer: an enabled biquad steps through ST_BQ, ST_Y, ST_Z1A, ST_Z1B,
// ST_Z2A and ST_Z2B, a bypassed one through ST_BQ and ST_Z2B only; the bass
// shaper and mix, load, output, the response hold and the idle state that takes
// the next transaction come on top. Each stall of the response side keeps the
// sequencer in ST_HOLD. A coefficient write transaction goes straight to
// coefficient memory when it is accepted. One transaction is in flight at a
// time; the result is held until the response side takes it.
module biquad_eq_bass_exciter_core
   import bqx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   bqx_req_if.sink     req,
   bqx_rsp_if.source   rsp,
   input  logic        csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);
   logic [15:0] headroom_ff;
   logic [14:0] mix_ff;
   logic [15:0] drive_ff;
   logic [NBQ-1:0] mask_ff;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic busy, out_valid, start, accept;
   dp_cmd_type cmd;
   coef_cmd_type ccmd;
   logic [CIDX_W-1:0] coef_rd_idx;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         headroom_ff <= 16'd32768; mix_ff <= '0; drive_ff <= 16'd8192; mask_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_HEADROOM: headroom_ff <= csr_wr_data;
            CSR_MIX:      mix_ff <= csr_wr_data[14:0];
            CSR_DRIVE:    drive_ff <= csr_wr_data;
            CSR_MASK:     mask_ff <= csr_wr_data[NBQ-1:0];
            default: ;
         endcase
      end
   end

   assign req.ready = !busy;
   assign accept = req.valid && req.ready;
   assign start = accept && (req.opcode == OP_SAMPLE);
   // coefficient writes go straight to memory; out-of-range indexes dropped
   assign ccmd.coef_wr = accept && (req.opcode == OP_COEF) &&
                         (req.coef_index < 6'(NCOEF));
   assign ccmd.coef_idx = CIDX_W'(req.coef_index);

   // latch the sample on acceptance
   always_ff @(posedge clock) begin
      if (start) sample_ff <= req.sample_in;
   end

   bqx_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .bass_on(mix_ff != '0),
      .mask(mask_ff), .out_taken(rsp.ready), .busy(busy), .out_valid(out_valid),
      .cmd(cmd), .coef_rd_idx(coef_rd_idx)
   );

   bqx_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .ccmd(ccmd), .coef_rd_idx(coef_rd_idx),
      .coef_wr_value(req.coef_value), .sample(sample_ff), .headroom_gain(headroom_ff),
      .bass_mix(mix_ff), .bass_drive(drive_ff), .out_sample(rsp.sample_out),
      .out_clipped(rsp.clipped_now), .out_count(rsp.clip_count)
   );

   assign rsp.valid = out_valid;
endmodule
